// ----- design/base93_keyed_text_codec_assert.svh -----
// ----------------------------------------------------------------------------
// base93_keyed_text_codec_assert.svh
// Assertion macros shared by the keyed base-93 codec RTL.
// ----------------------------------------------------------------------------
`ifndef BASE93_KEYED_TEXT_CODEC_ASSERT_SVH
`define BASE93_KEYED_TEXT_CODEC_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define B93KT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define B93KT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/b93kt_pkg.sv -----
// ----------------------------------------------------------------------------
// b93kt_pkg
// Widths, character codes, reciprocal constants and register indexes of the
// keyed base-93 text codec.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package b93kt_pkg;

	// field widths
	localparam int WordW  = 24;
	localparam int KeyW   = 26;
	localparam int CharW  = 7;
	localparam int SumW   = 27;
	localparam int DigW   = 7;
	localparam int HalfW  = 14;
	localparam int RecHiW = 28;
	localparam int ProdW  = SumW + RecHiW;

	// character codes
	localparam logic [CharW-1:0] PadChar = 7'd33;
	localparam logic [CharW-1:0] Digit0  = 7'd34;
	localparam logic [CharW-1:0] CharMax = 7'd126;

	// radix and largest four-digit value
	localparam logic [DigW-1:0]  Base   = 7'd93;
	localparam logic [HalfW-1:0] BaseSq = 14'd8649;
	localparam logic [SumW-1:0]  MaxVal = 27'd74805200;

	// rounded-up reciprocals: exact quotients over the value ranges used here
	localparam int HiShift = 41;
	localparam int LoShift = 20;
	localparam longint unsigned RecipHiL =
		((64'd1 << HiShift) + 64'd8649 - 64'd1) / 64'd8649;
	localparam longint unsigned RecipLoL =
		((64'd1 << LoShift) + 64'd93 - 64'd1) / 64'd93;
	localparam logic [RecHiW-1:0] RecipHi = RecHiW'(RecipHiL);
	localparam logic [HalfW-1:0]  RecipLo = HalfW'(RecipLoL);

	// configuration register indexes
	typedef enum logic {
		CFG_MODE = 1'b0,
		CFG_KEY  = 1'b1
	} cfg_idx_t;

	// operating mode
	typedef enum logic {
		MODE_ENC = 1'b0,
		MODE_DEC = 1'b1
	} mode_t;

endpackage

// ----- design/base93_keyed_text_codec.sv -----
// ----------------------------------------------------------------------------
// base93_keyed_text_codec: keyed base-93 word <-> four-character group codec.
// Pipeline: five register stages (s1 to s5) from input accept to out_valid.
// Throughput: one word per cycle unless out_ready stalls the pipe; the out_ready chain per stage closes bubbles.
// Reset: arst_n clears stage valids, mode (encode) and key (zero).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "base93_keyed_text_codec_assert.svh"

module base93_keyed_text_codec (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  b93kt_pkg::cfg_idx_t             cfg_index,
	input  logic [b93kt_pkg::KeyW-1:0]      cfg_data,
	// input words
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [b93kt_pkg::WordW-1:0]     word_in,
	input  logic [b93kt_pkg::CharW-1:0]     char_in0,
	input  logic [b93kt_pkg::CharW-1:0]     char_in1,
	input  logic [b93kt_pkg::CharW-1:0]     char_in2,
	input  logic [b93kt_pkg::CharW-1:0]     char_in3,
	// result words
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [b93kt_pkg::CharW-1:0]     char_out0,
	output logic [b93kt_pkg::CharW-1:0]     char_out1,
	output logic [b93kt_pkg::CharW-1:0]     char_out2,
	output logic [b93kt_pkg::CharW-1:0]     char_out3,
	output logic [b93kt_pkg::WordW-1:0]     word_out
);

	import b93kt_pkg::*;

	// configuration registers
	mode_t             mode_q;
	logic [KeyW-1:0]   key_q;

	// stage valids and advance chain
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic adv1, adv2, adv3, adv4, adv5;

	// per-word mode through the pipe
	mode_t mode_s1, mode_s2, mode_s3, mode_s4, mode_s5;

	// stage 1
	logic [SumW-1:0]   sum_c;
	logic [SumW-1:0]   val_s1;
	logic              ok0_c, ok1_c, ok2_c, ok3_c;
	logic [DigW-1:0]   dg0_c, dg1_c, dg2_c, dg3_c;
	logic [HalfW-1:0]  head_c;
	logic [HalfW-1:0]  head_s1;
	logic              ok2_s1, ok3_s1;
	logic [DigW-1:0]   dg2_s1, dg3_s1;

	// stage 2
	logic [ProdW-1:0]  prod_s2;
	logic [SumW-1:0]   val_s2;
	logic [SumW-1:0]   acc_c;
	logic [SumW-1:0]   acc_s2;

	// stage 3
	logic [HalfW-1:0]  hi_c;
	logic [SumW-1:0]   lo_c;
	logic [HalfW-1:0]  hi_s3, lo_s3;
	logic [WordW-1:0]  wout_s3;
	logic              keep_s3;

	// stage 4
	logic [SumW-1:0]   ph_s4, pl_s4;
	logic [HalfW-1:0]  hi_s4, lo_s4;
	logic [WordW-1:0]  wout_s4;

	// stage 5
	logic [DigW-1:0]   d3_c, d2_c, d1_c, d0_c;
	logic [HalfW-1:0]  r2_c, r0_c;
	logic [CharW-1:0]  ch_c [4];
	logic [CharW-1:0]  ch_s5 [4];
	logic [WordW-1:0]  wout_s5;

	// digit value of a character; anything outside the digit range is skipped
	function automatic logic [DigW:0] char_digit(input logic [CharW-1:0] c);
		logic [DigW-1:0] d;
		d = c - Digit0;
		if (c inside {[Digit0:CharMax]}) begin
			return {1'b1, d};
		end
		return {1'b0, d};
	endfunction

	// configuration writes, always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ENC;
			key_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MODE: mode_q <= mode_t'(cfg_data[0]);
				CFG_KEY:  key_q  <= cfg_data;
				default:  key_q  <= key_q;
			endcase
		end
	end

	// advance a stage when it is empty or the next one advances
	assign adv5     = !valid_s5 || out_ready;
	assign adv4     = !valid_s4 || adv5;
	assign adv3     = !valid_s3 || adv4;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= in_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
			// drop decoded groups whose value is zero
			if (adv4) valid_s4 <= valid_s3 && keep_s3;
			if (adv5) valid_s5 <= valid_s4;
		end
	end

	// stage 1: saturated keyed sum; decode the first two characters
	always_comb begin
		logic [DigW:0] t0, t1, t2, t3;
		sum_c = {3'b000, word_in} + {1'b0, key_q};
		t0    = char_digit(char_in0);
		t1    = char_digit(char_in1);
		t2    = char_digit(char_in2);
		t3    = char_digit(char_in3);
		ok0_c = t0[DigW];
		dg0_c = t0[DigW-1:0];
		ok1_c = t1[DigW];
		dg1_c = t1[DigW-1:0];
		ok2_c = t2[DigW];
		dg2_c = t2[DigW-1:0];
		ok3_c = t3[DigW];
		dg3_c = t3[DigW-1:0];
		if (ok0_c && ok1_c) begin
			head_c = HalfW'({7'b0, dg0_c} * {7'b0, Base}) + {7'b0, dg1_c};
		end else if (ok0_c) begin
			head_c = {7'b0, dg0_c};
		end else if (ok1_c) begin
			head_c = {7'b0, dg1_c};
		end else begin
			head_c = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			mode_s1 <= mode_q;
			val_s1  <= (sum_c > MaxVal) ? MaxVal : sum_c;
			head_s1 <= head_c;
			ok2_s1  <= ok2_c;
			dg2_s1  <= dg2_c;
			ok3_s1  <= ok3_c;
			dg3_s1  <= dg3_c;
		end
	end

	// stage 2: reciprocal product for the upper digit pair; finish decode sum
	always_comb begin
		logic [SumW-1:0] head_w, d2_w, d3_w;
		head_w = {13'b0, head_s1};
		d2_w   = {20'b0, dg2_s1};
		d3_w   = {20'b0, dg3_s1};
		case ({ok2_s1, ok3_s1})
			2'b11:   acc_c = head_w * SumW'(BaseSq) + d2_w * SumW'(Base) + d3_w;
			2'b10:   acc_c = head_w * SumW'(Base) + d2_w;
			2'b01:   acc_c = head_w * SumW'(Base) + d3_w;
			default: acc_c = head_w;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			mode_s2 <= mode_s1;
			prod_s2 <= {28'b0, val_s1} * {27'b0, RecipHi};
			val_s2  <= val_s1;
			acc_s2  <= acc_c;
		end
	end

	// stage 3: split into two base-8649 halves; subtract key for decode
	always_comb begin
		hi_c = prod_s2[HiShift +: HalfW];
		lo_c = val_s2 - {13'b0, hi_c} * SumW'(BaseSq);
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			mode_s3 <= mode_s2;
			hi_s3   <= hi_c;
			lo_s3   <= lo_c[HalfW-1:0];
			wout_s3 <= acc_s2[WordW-1:0] - key_q[WordW-1:0];
			keep_s3 <= (mode_s2 == MODE_ENC) || (acc_s2 != '0);
		end
	end

	// stage 4: reciprocal products for each half
	always_ff @(posedge clk) begin
		if (adv4) begin
			mode_s4 <= mode_s3;
			ph_s4   <= {13'b0, hi_s3} * {13'b0, RecipLo};
			pl_s4   <= {13'b0, lo_s3} * {13'b0, RecipLo};
			hi_s4   <= hi_s3;
			lo_s4   <= lo_s3;
			wout_s4 <= wout_s3;
		end
	end

	// stage 5: in encode mode four digits, most significant first, padded at the tail; all padding in decode mode
	always_comb begin
		d3_c = ph_s4[LoShift +: DigW];
		d1_c = pl_s4[LoShift +: DigW];
		r2_c = hi_s4 - HalfW'({7'b0, d3_c} * {7'b0, Base});
		r0_c = lo_s4 - HalfW'({7'b0, d1_c} * {7'b0, Base});
		d2_c = r2_c[DigW-1:0];
		d0_c = r0_c[DigW-1:0];
		ch_c[0] = PadChar;
		ch_c[1] = PadChar;
		ch_c[2] = PadChar;
		ch_c[3] = PadChar;
		if (mode_s4 == MODE_ENC) begin
			if (d3_c != '0) begin
				ch_c[0] = d3_c + Digit0;
				ch_c[1] = d2_c + Digit0;
				ch_c[2] = d1_c + Digit0;
				ch_c[3] = d0_c + Digit0;
			end else if (d2_c != '0) begin
				ch_c[0] = d2_c + Digit0;
				ch_c[1] = d1_c + Digit0;
				ch_c[2] = d0_c + Digit0;
			end else if (d1_c != '0) begin
				ch_c[0] = d1_c + Digit0;
				ch_c[1] = d0_c + Digit0;
			end else begin
				ch_c[0] = d0_c + Digit0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv5) begin
			mode_s5 <= mode_s4;
			ch_s5   <= ch_c;
			wout_s5 <= (mode_s4 == MODE_ENC) ? '0 : wout_s4;
		end
	end

	// drive the result word
	assign out_valid = valid_s5;
	assign char_out0 = ch_s5[0];
	assign char_out1 = ch_s5[1];
	assign char_out2 = ch_s5[2];
	assign char_out3 = ch_s5[3];
	assign word_out  = wout_s5;

	// checks
	`B93KT_ASSERT_NEXT(a_drop_zero, adv4 && valid_s3 && !keep_s3, !valid_s4, "zero group not dropped")
	`B93KT_ASSERT_NOW(a_split_range, valid_s3 && mode_s3 == MODE_ENC, (hi_s3 < BaseSq) && (lo_s3 < BaseSq), "digit pair split out of range")
	`B93KT_ASSERT_NOW(a_lead_digit, out_valid && mode_s5 == MODE_ENC, char_out0 != PadChar, "encoded group starts with padding")
	`B93KT_ASSERT_NEXT(a_stage_hold, valid_s4 && !adv5, valid_s4 && $stable(wout_s4) && $stable(ph_s4), "stalled stage 4 changed")

endmodule
